>>> hw/rtl/alfs_pkg.sv
package alfs_pkg;

    // Fixed field widths.
    localparam int CHAN_W    = 8;
    localparam int INTEN_W   = 9;
    localparam int CFG_W     = 7;
    localparam int PIX_W     = 24;
    localparam int PIX_BIT_W = 5;
    localparam int SYM_W     = 2;
    localparam int FUNC_W    = 2;

    // Intensity clamp limits in Q8.
    localparam logic [INTEN_W-1:0] INTENSITY_ONE = 9'd256;
    localparam logic [INTEN_W-1:0] INTENSITY_MIN = 9'd3;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    // Line symbol codes.
    localparam logic [SYM_W-1:0] SYM_ZERO = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ONE  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_TERM = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PIXEL_COUNT = 1'b0;
    localparam logic CFG_COLOR_ORDER = 1'b1;

    // Channel order codes.
    localparam logic [1:0] ORDER_BGR = 2'd1;
    localparam logic [1:0] ORDER_BRG = 2'd2;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_MUL      = 6'b000100,
        S_RD       = 6'b001000,
        S_WR       = 6'b010000,
        S_TICK_OUT = 6'b100000
    } t_state;

endpackage

>>> hw/rtl/alfs_ram.sv
module alfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/addressable_led_frame_serializer.sv
// Channel   | Direction | Handshake            | Ports
// ----------+-----------+----------------------+-----------------------------------------
// command   | in        | i_start & !o_busy    | i_func, i_red, i_green, i_blue, i_alpha,
//           |           |                      | i_intensity_q8, i_all_pixels, i_pixel_index
// result    | out       | o_valid, one cycle   | o_symbol, o_frame_last
// config    | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// A tick does one registered read of the pixel RAM, then the symbol is registered out.
// A tick that ends the frame, an apply and unused codes are handled from idle alone.
// A single-pixel set: the shared 8x9 multiplier scales one channel per cycle, then a
// read-compare-write of the RAM follows; an index past the strip skips the RAM.
// A set of all pixels does the read-compare-write once for every pixel of the strip.
// After reset the block is busy while it writes zero to every RAM entry.
// Results cannot be held off; each is shown for exactly one cycle.
module addressable_led_frame_serializer
    import alfs_pkg::*;
#(
    parameter int MAX_PIXELS     = 64,
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [CHAN_W-1:0]   i_red,
    input  logic [CHAN_W-1:0]   i_green,
    input  logic [CHAN_W-1:0]   i_blue,
    input  logic [CHAN_W-1:0]   i_alpha,
    input  logic [INTEN_W-1:0]  i_intensity_q8,
    input  logic                i_all_pixels,
    input  logic [5:0]          i_pixel_index,
    output logic                o_valid,
    output logic [SYM_W-1:0]    o_symbol,
    output logic                o_frame_last,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW  = $clog2(MAX_PIXELS + 1);
    localparam int WW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int SBW = $clog2(BITS_PER_PIXEL);
    localparam logic [SBW-1:0] BIT_TOP = SBW'(BITS_PER_PIXEL - 1);
    localparam logic [CW-1:0]  POS_END = CW'(MAX_PIXELS - 1);

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_pixel_count;
    logic [1:0]           r_color_order;
    logic                 r_flag, n_flag;
    logic                 r_frame_active, n_frame_active;
    logic [CW-1:0]        r_send_pixel, n_send_pixel;
    logic [SBW-1:0]       r_send_bit, n_send_bit;
    logic [CW-1:0]        r_pos, n_pos;
    logic [1:0]           r_ch, n_ch;
    logic                 r_valid, n_valid;
    logic [SYM_W-1:0]     r_symbol, n_symbol;
    logic                 r_frame_last, n_frame_last;

    // Payload of a set command.
    logic [CHAN_W-1:0]    r_chan [3];
    logic [CHAN_W-1:0]    r_scl  [3];
    logic [INTEN_W-1:0]   r_factor;
    logic                 r_black;
    logic                 r_all;
    logic                 r_go;

    logic                 w_accept;
    logic [WW-1:0]        w_count_w;
    logic [CW-1:0]        w_count;
    logic [INTEN_W-1:0]   w_factor;
    logic [16:0]          w_prod;
    logic [PIX_W-1:0]     w_word;
    logic [PIX_W-1:0]     w_rdata;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [PIX_W-1:0]     w_wdata;
    logic [AW-1:0]        w_raddr;
    logic                 w_pix_bit;
    logic [CW:0]          w_pos_inc;

    assign w_accept = i_start && !o_busy;
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_symbol     = r_symbol;
    assign o_frame_last = r_frame_last;

    // Effective pixel count saturates at the store depth.
    assign w_count_w = (WW'(r_pixel_count) > WW'(MAX_PIXELS)) ? WW'(MAX_PIXELS)
                                                               : WW'(r_pixel_count);
    assign w_count   = w_count_w[CW-1:0];

    // Intensity clamped to the Q8 range 3..256.
    always_comb begin
        if (i_intensity_q8 > INTENSITY_ONE) begin
            w_factor = INTENSITY_ONE;
        end else if (i_intensity_q8 < INTENSITY_MIN) begin
            w_factor = INTENSITY_MIN;
        end else begin
            w_factor = i_intensity_q8;
        end
    end

    // Shared multiplier: one channel is scaled per cycle.
    assign w_prod = 17'(r_chan[r_ch]) * 17'(r_factor);

    // Channel order for the strip word.
    always_comb begin
        case (r_color_order)
            ORDER_BGR: w_word = {r_scl[2], r_scl[1], r_scl[0]};
            ORDER_BRG: w_word = {r_scl[2], r_scl[0], r_scl[1]};
            default:   w_word = {r_scl[0], r_scl[1], r_scl[2]};
        endcase
        if (r_black) begin
            w_word = '0;
        end
    end

    // Pixel RAM port control.
    assign w_we    = (r_state == S_CLEAR) || (r_state == S_WR);
    assign w_waddr = r_pos[AW-1:0];
    assign w_wdata = (r_state == S_WR) ? w_word : '0;
    assign w_raddr = (r_state == S_IDLE) ? r_send_pixel[AW-1:0] : r_pos[AW-1:0];

    alfs_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_PIXELS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Bits above the stored word go out as zero bits.
    assign w_pix_bit = (r_send_bit < SBW'(PIX_W)) ? w_rdata[r_send_bit[PIX_BIT_W-1:0]] : 1'b0;
    assign w_pos_inc = {1'b0, r_pos} + (CW+1)'(1);

    // Sequencer next state.
    always_comb begin
        n_state        = r_state;
        n_flag         = r_flag;
        n_frame_active = r_frame_active;
        n_send_pixel   = r_send_pixel;
        n_send_bit     = r_send_bit;
        n_pos          = r_pos;
        n_ch           = r_ch;
        n_valid        = 1'b0;
        n_symbol       = r_symbol;
        n_frame_last   = r_frame_last;
        case (r_state)
            S_CLEAR: begin
                n_pos = w_pos_inc[CW-1:0];
                if (r_pos == POS_END) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        FUNC_SET: begin
                            n_state = S_MUL;
                            n_ch    = 2'd0;
                            n_pos   = i_all_pixels ? '0 : CW'(i_pixel_index);
                        end
                        FUNC_APPLY: begin
                            if (r_flag) begin
                                n_flag         = 1'b0;
                                n_frame_active = 1'b1;
                                n_send_pixel   = '0;
                                n_send_bit     = BIT_TOP;
                            end
                        end
                        FUNC_TICK: begin
                            if (r_frame_active) begin
                                if (r_send_pixel < w_count) begin
                                    n_state = S_TICK_OUT;
                                end else begin
                                    n_valid        = 1'b1;
                                    n_symbol       = SYM_TERM;
                                    n_frame_last   = 1'b1;
                                    n_frame_active = 1'b0;
                                    n_send_pixel   = '0;
                                    n_send_bit     = BIT_TOP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_ch = r_ch + 2'd1;
                if (r_ch == 2'd2) begin
                    n_state = r_go ? S_RD : S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (w_rdata != w_word) begin
                    n_flag = 1'b1;
                end
                n_pos = w_pos_inc[CW-1:0];
                if (r_all && (w_pos_inc < (CW+1)'(w_count))) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TICK_OUT: begin
                n_state      = S_IDLE;
                n_valid      = 1'b1;
                n_symbol     = w_pix_bit ? SYM_ONE : SYM_ZERO;
                n_frame_last = 1'b0;
                if (r_send_bit == '0) begin
                    n_send_bit   = BIT_TOP;
                    n_send_pixel = r_send_pixel + CW'(1);
                end else begin
                    n_send_bit = r_send_bit - SBW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_flag         <= 1'b0;
            r_frame_active <= 1'b0;
            r_send_pixel   <= '0;
            r_send_bit     <= BIT_TOP;
            r_pos          <= '0;
            r_ch           <= '0;
            r_valid        <= 1'b0;
            r_pixel_count  <= '0;
            r_color_order  <= '0;
        end else begin
            r_state        <= n_state;
            r_flag         <= n_flag;
            r_frame_active <= n_frame_active;
            r_send_pixel   <= n_send_pixel;
            r_send_bit     <= n_send_bit;
            r_pos          <= n_pos;
            r_ch           <= n_ch;
            r_valid        <= n_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PIXEL_COUNT) begin
                    r_pixel_count <= i_cfg_data;
                end else if (i_cfg_index == CFG_COLOR_ORDER) begin
                    r_color_order <= i_cfg_data[1:0];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_symbol     <= n_symbol;
        r_frame_last <= n_frame_last;
        if (w_accept && (i_func == FUNC_SET)) begin
            r_chan[0] <= i_red;
            r_chan[1] <= i_green;
            r_chan[2] <= i_blue;
            r_factor  <= w_factor;
            r_black   <= (i_intensity_q8 == '0) || (i_alpha == '0)
                         || ((i_red | i_green | i_blue) == '0);
            r_all     <= i_all_pixels;
            r_go      <= i_all_pixels ? (w_count != '0)
                                      : (WW'(i_pixel_index) < w_count_w);
        end
        if (r_state == S_MUL) begin
            r_scl[r_ch] <= w_prod[15:8];
        end
    end

    // A result only follows a tick.
    a_valid_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past((r_state == S_TICK_OUT) || (w_accept && (i_func == FUNC_TICK))))
        else $error("result without a tick");

    // The terminator closes the frame.
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_frame_last) |-> !r_frame_active)
        else $error("frame still active after terminator");

    // With no frame active the sender waits at the first pixel.
    a_idle_sender: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_active |-> ((r_send_pixel == '0) && (r_send_bit == BIT_TOP)))
        else $error("sender position off while no frame active");

endmodule
